>>> hdl/sstd_pkg.sv
// ----------------------------------------------------------------------------
// sstd_pkg: shared types and constants of the shadow store dirty tracker
// Command codes, sizes, the state type of the sequencer and the structs that
// travel between the sequencer and the top level.
// ----------------------------------------------------------------------------
package sstd_pkg;

    // Capacity of the shadow store in bytes.
    localparam int MAX_BYTES  = 4096;
    localparam int ADDR_W     = $clog2(MAX_BYTES);
    // Width of the size register and of the size in use.
    localparam int SIZE_W     = 13;
    localparam int DATA_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 4;
    localparam int BIT_W      = 3;
    // Byte count of a 32-bit word; the range check reaches one byte past it.
    localparam int WORD32_LEN = 4;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_RD_BYTE  = 4'd0,
        CMD_WR_BYTE  = 4'd1,
        CMD_RD_BIT   = 4'd2,
        CMD_WR_BIT   = 4'd3,
        CMD_RD16     = 4'd4,
        CMD_WR16     = 4'd5,
        CMD_RD32     = 4'd6,
        CMD_WR32     = 4'd7,
        CMD_SCAN     = 4'd8,
        CMD_CLR_DIRT = 4'd9
    } t_cmd;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Memory requests from the sequencer to both RAMs.
    typedef struct packed {
        logic              sh_we;
        logic [ADDR_W-1:0] sh_waddr;
        logic [BYTE_W-1:0] sh_wdata;
        logic [ADDR_W-1:0] sh_raddr;
        logic              dt_we;
        logic [ADDR_W-1:0] dt_waddr;
        logic              dt_wdata;
        logic [ADDR_W-1:0] dt_raddr;
    } t_mem_req;

    // Finished result offered to the output register.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic              err;
    } t_done;

endpackage

>>> hdl/sstd_ram.sv
// ----------------------------------------------------------------------------
// sstd_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module sstd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sstd_check.sv
// ----------------------------------------------------------------------------
// sstd_check: address range check
// Decides whether an access starting at an address, with the check end that
// its command implies, lies inside the size in use.
// ----------------------------------------------------------------------------
module sstd_check (
    input  sstd_pkg::t_cmd                  i_cmd,
    input  logic [sstd_pkg::ADDR_W-1:0]     i_addr,
    input  logic [sstd_pkg::SIZE_W-1:0]     i_size,
    output logic                            o_ok
);
    import sstd_pkg::*;

    logic [SIZE_W-1:0] w_offset;
    logic [SIZE_W-1:0] w_start;
    logic [SIZE_W-1:0] w_end;

    // The check end lies one byte on for 16-bit access and a whole word on
    // for 32-bit access.
    always_comb begin
        case (i_cmd) inside
            CMD_RD16, CMD_WR16: w_offset = SIZE_W'(1);
            CMD_RD32, CMD_WR32: w_offset = SIZE_W'(WORD32_LEN);
            default:            w_offset = '0;
        endcase
    end

    assign w_start = {{(SIZE_W-ADDR_W){1'b0}}, i_addr};
    assign w_end   = w_start + w_offset;

    // Address zero is reserved; start and end must both be below the size.
    assign o_ok = (i_addr != '0) && (w_start < i_size) && (w_end < i_size);

endmodule

>>> hdl/sstd_seq.sv
// ----------------------------------------------------------------------------
// sstd_seq: command sequencer
// Runs the clearing pass after reset, the byte-by-byte read-modify-write of
// the shadow store, the dirty flag updates and the dirty scan.
// ----------------------------------------------------------------------------
module sstd_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  sstd_pkg::t_cmd                  i_command,
    input  logic [sstd_pkg::ADDR_W-1:0]     i_address,
    input  logic [sstd_pkg::BIT_W-1:0]      i_bit_index,
    input  logic [sstd_pkg::DATA_W-1:0]     i_write_value,
    input  logic                            i_mark_dirty,
    input  logic                            i_range_ok,
    input  logic [sstd_pkg::SIZE_W-1:0]     i_size,
    input  logic                            i_out_free,
    output sstd_pkg::t_done                 o_done,
    output sstd_pkg::t_mem_req              o_mem,
    input  logic [sstd_pkg::BYTE_W-1:0]     i_shadow_rdata,
    input  logic                            i_dirty_rdata
);
    import sstd_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [DATA_W-1:0] r_wv, n_wv;
    logic              r_mark, n_mark;
    logic [1:0]        r_k, n_k;
    logic [1:0]        r_last, n_last;
    logic [ADDR_W-1:0] r_scan, n_scan;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_err, n_err;

    logic              w_accept;
    logic              w_last_byte;
    logic              w_scan_end;
    logic              w_is_write;
    logic [1:0]        w_lane;
    logic [ADDR_W-1:0] w_addr_k;
    logic [BYTE_W-1:0] w_new_byte;
    logic [BYTE_W-1:0] w_bit_mask;
    logic              w_changed;
    logic [SIZE_W-1:0] w_scan_next;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_last_byte = (r_k == r_last);
    assign w_scan_next = {1'b0, r_scan} + SIZE_W'(1);
    assign w_scan_end  = (w_scan_next >= i_size);

    // Byte lane of the current byte: 16-bit words are big-endian.
    always_comb begin
        case (r_cmd) inside
            CMD_RD16, CMD_WR16: w_lane = {1'b0, ~r_k[0]};
            default:            w_lane = r_k;
        endcase
    end

    assign w_addr_k   = r_addr + ADDR_W'(r_k);
    assign w_bit_mask = BYTE_W'(1) << r_bit;

    // New value of the current byte for the write commands.
    always_comb begin
        case (r_cmd) inside
            CMD_WR_BIT: begin
                w_new_byte = r_wv[0] ? (i_shadow_rdata | w_bit_mask)
                                     : (i_shadow_rdata & ~w_bit_mask);
            end
            default: w_new_byte = r_wv[{w_lane, 3'b000} +: BYTE_W];
        endcase
    end

    always_comb begin
        case (r_cmd) inside
            CMD_WR_BYTE, CMD_WR_BIT, CMD_WR16, CMD_WR32: w_is_write = 1'b1;
            default:                                     w_is_write = 1'b0;
        endcase
    end

    assign w_changed = w_is_write && (w_new_byte != i_shadow_rdata);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_command) inside
                        CMD_RD_BYTE, CMD_WR_BYTE, CMD_RD_BIT, CMD_WR_BIT,
                        CMD_RD16, CMD_WR16, CMD_RD32, CMD_WR32: begin
                            n_state = i_range_ok ? ST_ACC : ST_FIN;
                        end
                        CMD_SCAN: begin
                            n_state = (i_size > SIZE_W'(1)) ? ST_SCAN : ST_FIN;
                        end
                        default: n_state = ST_FIN;
                    endcase
                end
            end
            ST_ACC: begin
                if (w_last_byte) begin
                    n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (i_dirty_rdata || w_scan_end) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath, memory requests and the finished result.
    always_comb begin
        n_cmd  = r_cmd;
        n_addr = r_addr;
        n_bit  = r_bit;
        n_wv   = r_wv;
        n_mark = r_mark;
        n_k    = r_k;
        n_last = r_last;
        n_scan = r_scan;
        n_clr  = r_clr;
        n_data = r_data;
        n_err  = r_err;
        o_mem  = '0;
        o_done = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_mem.sh_we    = 1'b1;
                o_mem.sh_waddr = r_clr;
                o_mem.dt_we    = 1'b1;
                o_mem.dt_waddr = r_clr;
                n_clr          = r_clr + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmd  = i_command;
                    n_addr = i_address;
                    n_bit  = i_bit_index;
                    n_wv   = i_write_value;
                    n_mark = i_mark_dirty;
                    n_k    = '0;
                    n_data = '0;
                    n_err  = 1'b0;
                    case (i_command) inside
                        CMD_RD_BYTE, CMD_WR_BYTE, CMD_RD_BIT, CMD_WR_BIT: begin
                            n_last         = 2'd0;
                            n_err          = !i_range_ok;
                            o_mem.sh_raddr = i_address;
                        end
                        CMD_RD16, CMD_WR16: begin
                            n_last         = 2'd1;
                            n_err          = !i_range_ok;
                            o_mem.sh_raddr = i_address;
                        end
                        CMD_RD32, CMD_WR32: begin
                            n_last         = 2'(WORD32_LEN - 1);
                            n_err          = !i_range_ok;
                            o_mem.sh_raddr = i_address;
                        end
                        CMD_SCAN: begin
                            // Walk starts at address one; small sizes answer at once.
                            n_scan         = ADDR_W'(1);
                            o_mem.dt_raddr = ADDR_W'(1);
                            if (i_size <= SIZE_W'(1)) begin
                                n_data = {{(DATA_W-SIZE_W){1'b0}}, i_size};
                            end
                        end
                        CMD_CLR_DIRT: begin
                            n_err          = !i_range_ok;
                            o_mem.dt_we    = i_range_ok;
                            o_mem.dt_waddr = i_address;
                            o_mem.dt_wdata = 1'b0;
                        end
                        default: n_err = 1'b1;
                    endcase
                end
            end
            ST_ACC: begin
                // Write back only a changed byte; its flag is set on request.
                o_mem.sh_we    = w_changed;
                o_mem.sh_waddr = w_addr_k;
                o_mem.sh_wdata = w_new_byte;
                o_mem.dt_we    = w_changed && r_mark;
                o_mem.dt_waddr = w_addr_k;
                o_mem.dt_wdata = 1'b1;
                case (r_cmd) inside
                    CMD_RD_BIT: begin
                        n_data = {{(DATA_W-1){1'b0}}, i_shadow_rdata[r_bit]};
                    end
                    CMD_RD_BYTE, CMD_RD16, CMD_RD32: begin
                        n_data = r_data |
                                 (DATA_W'(i_shadow_rdata) << {w_lane, 3'b000});
                    end
                    default: n_data = r_data;
                endcase
                // Read of the next byte overlaps the write of this one.
                if (!w_last_byte) begin
                    n_k            = r_k + 2'd1;
                    o_mem.sh_raddr = w_addr_k + ADDR_W'(1);
                end
            end
            ST_SCAN: begin
                if (i_dirty_rdata) begin
                    n_data = {{(DATA_W-ADDR_W){1'b0}}, r_scan};
                end else if (w_scan_end) begin
                    n_data = {{(DATA_W-SIZE_W){1'b0}}, i_size};
                end else begin
                    n_scan         = r_scan + ADDR_W'(1);
                    o_mem.dt_raddr = r_scan + ADDR_W'(1);
                end
            end
            ST_FIN: begin
                o_done.valid = 1'b1;
                o_done.data  = r_data;
                o_done.err   = r_err;
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_bit  <= n_bit;
        r_wv   <= n_wv;
        r_mark <= n_mark;
        r_k    <= n_k;
        r_last <= n_last;
        r_scan <= n_scan;
        r_data <= n_data;
        r_err  <= n_err;
    end

endmodule

>>> hdl/shadow_store_dirty_tracker_core.sv
// ----------------------------------------------------------------------------
// shadow_store_dirty_tracker_core: byte shadow store with dirty flags
// Top level: stream ports, size register, range check, the two RAMs, the
// command sequencer and the result register.
// ----------------------------------------------------------------------------
// After reset the block clears all 4096 entries of both memories, one entry a
// cycle; s_axis_tready stays low during that pass while size writes are taken.
// Every command is then accepted, touches its bytes in the shadow RAM one byte
// per cycle (read of the next byte overlapping the write of this one) and hands
// over its result, waiting while the output register is still full. Rejected
// accesses, unknown commands and clear dirty go from the accept straight to the
// hand-over. A scan reads one dirty flag a cycle through the dirty RAM's read
// port and examines up to the size in use minus one flags, stopping at the first
// dirty one. A result waits in the output register while the next command is
// accepted.
module shadow_store_dirty_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Size register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data,     // store_size
    // Command beats.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[3:0], address[15:4], bit_index[18:16], write_value[50:19],
    // mark_dirty[51], zero fill[55:52]
    input  logic [55:0] s_axis_tdata,
    // Result beats.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0], access_error[32], zero fill[39:33]
    output logic [39:0] m_axis_tdata
);
    import sstd_pkg::*;

    logic [SIZE_W-1:0] r_store_size;
    logic [SIZE_W-1:0] w_size;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_err;

    t_cmd              w_cmd;
    logic [ADDR_W-1:0] w_addr;
    logic [BIT_W-1:0]  w_bit;
    logic [DATA_W-1:0] w_wv;
    logic              w_mark;
    logic              w_range_ok;
    logic              w_out_free;
    t_done             w_done;
    t_mem_req          w_mem;
    logic [BYTE_W-1:0] w_shadow_rdata;
    logic              w_dirty_rdata;

    // Unpack the command beat.
    assign w_cmd  = t_cmd'(s_axis_tdata[3:0]);
    assign w_addr = s_axis_tdata[15:4];
    assign w_bit  = s_axis_tdata[18:16];
    assign w_wv   = s_axis_tdata[50:19];
    assign w_mark = s_axis_tdata[51];

    // Size register; a size above capacity acts as the capacity.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_size <= SIZE_W'(MAX_BYTES);
        end else if (i_cfg_valid) begin
            r_store_size <= i_cfg_data;
        end
    end
    assign w_size = (r_store_size > SIZE_W'(MAX_BYTES)) ? SIZE_W'(MAX_BYTES)
                                                        : r_store_size;

    sstd_check u_check (
        .i_cmd  (w_cmd),
        .i_addr (w_addr),
        .i_size (w_size),
        .o_ok   (w_range_ok)
    );

    sstd_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_command      (w_cmd),
        .i_address      (w_addr),
        .i_bit_index    (w_bit),
        .i_write_value  (w_wv),
        .i_mark_dirty   (w_mark),
        .i_range_ok     (w_range_ok),
        .i_size         (w_size),
        .i_out_free     (w_out_free),
        .o_done         (w_done),
        .o_mem          (w_mem),
        .i_shadow_rdata (w_shadow_rdata),
        .i_dirty_rdata  (w_dirty_rdata)
    );

    sstd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_BYTES)
    ) u_shadow_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.sh_we),
        .i_waddr (w_mem.sh_waddr),
        .i_wdata (w_mem.sh_wdata),
        .i_raddr (w_mem.sh_raddr),
        .o_rdata (w_shadow_rdata)
    );

    sstd_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BYTES)
    ) u_dirty_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.dt_we),
        .i_waddr (w_mem.dt_waddr),
        .i_wdata (w_mem.dt_wdata),
        .i_raddr (w_mem.dt_raddr),
        .o_rdata (w_dirty_rdata)
    );

    // Result register: takes a finished result once the last one is gone.
    assign w_out_free = !r_out_valid || m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_done.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_out_free && w_done.valid) begin
            r_out_data <= w_done.data;
            r_out_err  <= w_done.err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_err, r_out_data};

    // One command at a time: the sequencer leaves idle on every accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command accepted while the previous one is at work");

    // A rejected access answers with zero data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_data == '0))
        else $error("error result carries nonzero data");

    // A finished result that finds the output register busy is held.
    a_done_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done.valid && !w_out_free) |=> (w_done.valid && $stable(w_done.data)))
        else $error("finished result dropped while the output was busy");

endmodule

>>> dv/tb_shadow_store_dirty_tracker_core.sv
// ----------------------------------------------------------------------------
// tb_shadow_store_dirty_tracker_core: self-checking bench of the shadow store
// A scoreboard class mirrors the byte store, the dirty flags and the size
// register, predicts one result beat per command beat and checks every result
// in order. Stimulus is a short directed list followed by random phases,
// each under a different store size, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb_shadow_store_dirty_tracker_core;
    import sstd_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    // Long sink hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES  = 300;
    // Clearing pass plus a full scan plus the hold-off, taken several times.
    localparam int IDLE_LIMIT   = 40000;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_PHASES   = 16;
    localparam int HOT_SPAN     = 32;

    // Codes outside the command set; the block must reject them.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd10;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;

    // Command beat fields, lowest field in the lowest bits.
    typedef struct packed {
        logic              mark;
        logic [DATA_W-1:0] wval;
        logic [BIT_W-1:0]  bit_pos;
        logic [ADDR_W-1:0] addr;
        logic [CMD_W-1:0]  code;
    } command_t;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              err;
    } reply_t;

    // Mirror of the store: predicts result beats and checks them in order.
    class shadow_store_checker;
        logic [BYTE_W-1:0] shadow_mem[MAX_BYTES];
        bit                dirty_mem[MAX_BYTES];
        logic [SIZE_W-1:0] size_reg;
        reply_t            pending_replies[$];
        int unsigned       failures;
        int unsigned       n_commands;
        int unsigned       n_scans;
        int unsigned       n_rejected;
        int unsigned       n_sizes;

        function new();
            foreach (shadow_mem[k]) begin
                shadow_mem[k] = '0;
                dirty_mem[k]  = 1'b0;
            end
            size_reg   = SIZE_W'(MAX_BYTES);
            failures   = 0;
            n_commands = 0;
            n_scans    = 0;
            n_rejected = 0;
            n_sizes    = 0;
        endfunction

        function int unsigned active_size();
            return (size_reg > MAX_BYTES) ? MAX_BYTES : size_reg;
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            size_reg = value;
            n_sizes++;
        endfunction

        function int unsigned outstanding();
            return pending_replies.size();
        endfunction

        function bit in_range(int unsigned first, int unsigned last);
            int unsigned lim;
            lim = active_size();
            return first >= 1 && first < lim && last >= 1 && last < lim;
        endfunction

        function logic [BYTE_W-1:0] peek(int unsigned a);
            return (a < MAX_BYTES) ? shadow_mem[a] : '0;
        endfunction

        // Only a changed byte is written, and only then can it turn dirty.
        function void poke(int unsigned a, logic [BYTE_W-1:0] value, logic mark);
            if (a >= MAX_BYTES)
                return;
            if (shadow_mem[a] != value) begin
                shadow_mem[a] = value;
                if (mark)
                    dirty_mem[a] = 1'b1;
            end
        endfunction

        // Applies one accepted command beat and queues the result it causes.
        function void predict_command(command_t c);
            reply_t            want;
            int unsigned       a;
            int unsigned       lim;
            logic [BYTE_W-1:0] b;

            want.data = '0;
            want.err  = 1'b0;
            a   = c.addr;
            lim = active_size();
            n_commands++;
            case (c.code)
                CMD_RD_BYTE: begin
                    if (in_range(a, a)) want.data = DATA_W'(peek(a));
                    else want.err = 1'b1;
                end
                CMD_WR_BYTE: begin
                    if (in_range(a, a)) poke(a, c.wval[7:0], c.mark);
                    else want.err = 1'b1;
                end
                CMD_RD_BIT: begin
                    if (in_range(a, a)) begin
                        b = peek(a);
                        want.data = DATA_W'(b[c.bit_pos]);
                    end else begin
                        want.err = 1'b1;
                    end
                end
                CMD_WR_BIT: begin
                    if (in_range(a, a)) begin
                        b = peek(a);
                        b[c.bit_pos] = c.wval[0];
                        poke(a, b, c.mark);
                    end else begin
                        want.err = 1'b1;
                    end
                end
                // Sixteen-bit words are big-endian.
                CMD_RD16: begin
                    if (in_range(a, a + 1)) want.data = {16'h0, peek(a), peek(a + 1)};
                    else want.err = 1'b1;
                end
                CMD_WR16: begin
                    if (in_range(a, a + 1)) begin
                        poke(a, c.wval[15:8], c.mark);
                        poke(a + 1, c.wval[7:0], c.mark);
                    end else begin
                        want.err = 1'b1;
                    end
                end
                // Thirty-two-bit words are little-endian; the check reaches
                // one byte past the word.
                CMD_RD32: begin
                    if (in_range(a, a + WORD32_LEN))
                        want.data = {peek(a + 3), peek(a + 2), peek(a + 1), peek(a)};
                    else
                        want.err = 1'b1;
                end
                CMD_WR32: begin
                    if (in_range(a, a + WORD32_LEN)) begin
                        for (int k = 0; k < WORD32_LEN; k++)
                            poke(a + k, c.wval[8*k +: 8], c.mark);
                    end else begin
                        want.err = 1'b1;
                    end
                end
                // Lowest dirty address from 1 up, or the size when none is.
                CMD_SCAN: begin
                    n_scans++;
                    want.data = lim;
                    for (int unsigned k = 1; k < lim; k++) begin
                        if (dirty_mem[k]) begin
                            want.data = k;
                            break;
                        end
                    end
                end
                CMD_CLR_DIRT: begin
                    if (in_range(a, a) && a < MAX_BYTES) dirty_mem[a] = 1'b0;
                    else want.err = 1'b1;
                end
                default: begin
                    want.err = 1'b1;
                end
            endcase
            if (want.err)
                n_rejected++;
            pending_replies.push_back(want);
        endfunction

        // Compares one accepted result beat with the oldest prediction.
        function void check_response(logic [DATA_W-1:0] data, logic err);
            reply_t want;
            if (pending_replies.size() == 0) begin
                failures++;
                $display("%0t: result beat with nothing pending: read_data=%h access_error=%b",
                         $time, data, err);
                return;
            end
            want = pending_replies.pop_front();
            if (data !== want.data) begin
                failures++;
                $display("%0t: read_data expected %h, actual %h", $time, want.data, data);
            end
            if (err !== want.err) begin
                failures++;
                $display("%0t: access_error expected %b, actual %b", $time, want.err, err);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    shadow_store_checker store_check;
    command_t            beat_cmd;
    command_t            last_write;
    bit                  have_write;
    bit                  hold_req;
    int unsigned         hot_base;

    shadow_store_dirty_tracker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Beat monitor: size writes and command beats feed the mirror, result
    // beats are checked against it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                store_check.set_size(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                beat_cmd = s_axis_tdata[51:0];
                store_check.predict_command(beat_cmd);
            end
            if (m_axis_tvalid && m_axis_tready)
                store_check.check_response(m_axis_tdata[31:0], m_axis_tdata[32]);
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("shadow_store_dirty_tracker_core: mismatch");
        $finish;
    end

    // Result sink: alternates between always ready, a rotating stall pattern
    // and random stalls, and honors one long hold-off on request.
    initial begin
        int          hold_left;
        int          mode_left;
        int          mode;
        logic [15:0] stall_pattern;

        hold_left     = 0;
        mode_left     = 0;
        mode          = 0;
        stall_pattern = 16'hFFFF;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode          = $urandom_range(0, 2);
                mode_left     = $urandom_range(20, 200);
                stall_pattern = 16'($urandom) | 16'h0001;
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: begin
                        m_axis_tready <= stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                    end
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic command_t make_cmd(logic [CMD_W-1:0] code, logic [ADDR_W-1:0] addr,
                                          logic [BIT_W-1:0] bit_pos, logic [DATA_W-1:0] wval,
                                          logic mark);
        command_t c;
        c.code    = code;
        c.addr    = addr;
        c.bit_pos = bit_pos;
        c.wval    = wval;
        c.mark    = mark;
        return c;
    endfunction

    // Random command: mostly accesses in a hot window and near the size
    // edge, reads that follow the write before them, plus scans, clears and
    // unknown codes.
    function automatic command_t random_command(int unsigned lim);
        command_t c;
        int       pick;
        int       a;

        if (have_write && $urandom_range(0, 2) != 0) begin
            c = last_write;
            have_write = 1'b0;
            case (last_write.code)
                CMD_WR_BYTE: c.code = CMD_RD_BYTE;
                CMD_WR_BIT:  c.code = CMD_RD_BIT;
                CMD_WR16:    c.code = CMD_RD16;
                default:     c.code = CMD_RD32;
            endcase
            return c;
        end

        c.wval    = $urandom;
        c.mark    = 1'($urandom_range(0, 1));
        c.bit_pos = BIT_W'($urandom_range(0, 7));

        pick = $urandom_range(0, 9);
        if (pick < 2)
            a = $urandom_range(0, MAX_BYTES - 1);
        else if (pick < 4)
            a = int'(lim) - 6 + $urandom_range(0, 7);
        else if (pick == 4)
            a = $urandom_range(0, 1);
        else
            a = hot_base + $urandom_range(0, HOT_SPAN - 1);
        if (a < 0)
            a = 0;
        if (a > MAX_BYTES - 1)
            a = MAX_BYTES - 1;
        c.addr = ADDR_W'(a);

        pick = $urandom_range(0, 99);
        if (pick < 3)
            c.code = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        else if (pick < 9)
            c.code = CMD_SCAN;
        else if (pick < 19)
            c.code = CMD_CLR_DIRT;
        else
            c.code = CMD_W'($urandom_range(CMD_RD_BYTE, CMD_WR32));

        if (c.code == CMD_WR_BYTE || c.code == CMD_WR_BIT || c.code == CMD_WR16 ||
            c.code == CMD_WR32) begin
            last_write = c;
            have_write = 1'b1;
        end
        return c;
    endfunction

    // Offers one command beat and returns at the edge that accepts it.
    task automatic push_command(command_t c);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, c};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Random command beats in bursts, with or without gaps between them.
    task automatic run_commands(int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        bit          steady;

        sent   = 0;
        steady = ($urandom_range(0, 3) == 0);
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < count) begin
                push_command(random_command(store_check.active_size()));
                sent++;
                burst--;
            end
            gap = steady ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Writes the size register once every pending result has come back.
    task automatic set_store_size(logic [SIZE_W-1:0] value);
        @(posedge i_clk);
        while (store_check.outstanding() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned phase_size[NUM_PHASES];
        int unsigned phase_items[NUM_PHASES];
        int unsigned lim;

        store_check = new();
        have_write  = 1'b0;
        hold_req    = 1'b0;
        hot_base    = 0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;

        phase_size  = '{40, 0, 6, 5, 1, 2, 16, 8191, 24, 4097, 4095, 100, 4096, 7, 300, 0};
        phase_items = '{120, 60, 150, 150, 60, 60, 200, 100, 200, 100, 100, 200, 80, 120,
                        100, 100};
        phase_size[NUM_PHASES-1] = $urandom_range(0, 8191);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full size, written while the clearing pass still runs.
        set_store_size(SIZE_W'(MAX_BYTES));

        // Directed: clean scan, dirty marking and clearing, the reserved
        // address, word accesses at the top edge of the store, unchanged
        // writes that must stay clean, and unknown codes.
        push_command(make_cmd(CMD_SCAN,       12'd0,    3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_WR_BYTE,    12'd1,    3'd0, 32'h000000A5, 1'b1));
        push_command(make_cmd(CMD_RD_BYTE,    12'd1,    3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_SCAN,       12'd0,    3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_CLR_DIRT,   12'd1,    3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_SCAN,       12'd4095, 3'd7, 32'h0,        1'b0));
        push_command(make_cmd(CMD_WR_BYTE,    12'd0,    3'd0, 32'hFF,       1'b1));
        push_command(make_cmd(CMD_WR32,       12'd4091, 3'd0, 32'hDEADBEEF, 1'b0));
        push_command(make_cmd(CMD_RD32,       12'd4091, 3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_RD32,       12'd4092, 3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_WR16,       12'd4094, 3'd0, 32'hFFFF1234, 1'b1));
        push_command(make_cmd(CMD_RD16,       12'd4094, 3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_RD16,       12'd4095, 3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_WR_BIT,     12'd4095, 3'd7, 32'h1,        1'b1));
        push_command(make_cmd(CMD_RD_BIT,     12'd4095, 3'd7, 32'h0,        1'b0));
        push_command(make_cmd(CMD_RD_BYTE,    12'd4095, 3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_WR_BYTE,    12'd2,    3'd0, 32'hFFFFFF00, 1'b1));
        push_command(make_cmd(CMD_SCAN,       12'd0,    3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_UNKNOWN_HI, 12'd5,    3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_UNKNOWN_LO, 12'd5,    3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_WR_BIT,     12'd4095, 3'd0, 32'h0,        1'b1));
        push_command(make_cmd(CMD_CLR_DIRT,   12'd0,    3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_RD_BYTE,    12'd0,    3'd0, 32'h0,        1'b0));
        push_command(make_cmd(CMD_WR32,       12'd1,    3'd0, 32'hFFFFFFFF, 1'b1));
        push_command(make_cmd(CMD_RD_BIT,     12'd3,    3'd0, 32'h0,        1'b0));
        s_axis_tvalid <= 1'b0;

        // Random phases, one size setting each; a tiny store in the third
        // phase takes the long sink hold-off.
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_store_size(SIZE_W'(phase_size[p]));
            lim = (phase_size[p] > MAX_BYTES) ? MAX_BYTES : phase_size[p];
            hot_base = (lim <= 2 * HOT_SPAN) ? 0 : $urandom_range(0, lim - HOT_SPAN);
            have_write = 1'b0;
            if (p == 2)
                hold_req = 1'b1;
            run_commands(phase_items[p]);
        end

        // Drain, then give a stray beat time to show up.
        while (store_check.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (store_check.outstanding() != 0) begin
            store_check.failures++;
            $display("%0t: %0d results never arrived", $time, store_check.outstanding());
        end

        $display("Ran %0d commands under %0d size settings: %0d dirty scans, %0d rejected.",
                 store_check.n_commands, store_check.n_sizes, store_check.n_scans,
                 store_check.n_rejected);
        $display("Failed checks: %0d", store_check.failures);
        if (store_check.failures == 0)
            $display("shadow_store_dirty_tracker_core: match");
        else
            $display("shadow_store_dirty_tracker_core: mismatch");
        $finish;
    end

endmodule
